@@ rtl/lfu_pkg.sv @@
package lfu_pkg;

  localparam int OPCODE_W = 2;
  localparam int FIELD_W  = 16;
  localparam int CFG_W    = 7;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_BITS_DEF  = 16;
  localparam int USE_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] CAP_MIN   = CFG_W'(1);

  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // flags of the scan token that walks the cell row
  typedef struct packed {
    logic active;
    logic found;
    logic have;
  } tok_flags_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic en;
    logic evict;
  } commit_t;

endpackage

@@ rtl/lfu_channels.sv @@
interface lfu_req_if;
  logic                              valid;
  logic                              ready;
  logic [lfu_pkg::OPCODE_W-1:0]      opcode;
  logic [lfu_pkg::FIELD_W-1:0]       file_id;
  logic [lfu_pkg::FIELD_W-1:0]       seg_id;

  modport source (output valid, opcode, file_id, seg_id, input ready);
  modport sink (input valid, opcode, file_id, seg_id, output ready);
endinterface

interface lfu_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic                              evicted;
  logic [lfu_pkg::FIELD_W-1:0]       evicted_file_id;
  logic [lfu_pkg::FIELD_W-1:0]       evicted_seg_id;

  modport source (output valid, hit, evicted, evicted_file_id, evicted_seg_id, input ready);
  modport sink (input valid, hit, evicted, evicted_file_id, evicted_seg_id, output ready);
endinterface

interface lfu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lfu_pkg::CFG_W-1:0]         data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/lfu_cell.sv @@
module lfu_cell #(
  parameter int CAPACITY = lfu_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = lfu_pkg::ID_BITS_DEF,
  parameter int USE_BITS = lfu_pkg::USE_BITS_DEF,
  parameter int INDEX    = 0,
  localparam int IDX_W   = $clog2(CAPACITY),
  localparam int OCC_W   = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [OCC_W-1:0]        occ,
  input  logic                    is_read,
  input  logic [ID_BITS-1:0]      key_file,
  input  logic [ID_BITS-1:0]      key_seg,
  input  lfu_pkg::commit_t        cmd,
  input  logic [IDX_W-1:0]        victim_idx,
  input  logic [IDX_W-1:0]        append_idx,
  input  logic [ID_BITS-1:0]      nb_file,
  input  logic [ID_BITS-1:0]      nb_seg,
  input  logic [USE_BITS-1:0]     nb_uses,
  output logic [ID_BITS-1:0]      ent_file,
  output logic [ID_BITS-1:0]      ent_seg,
  output logic [USE_BITS-1:0]     ent_uses,
  input  lfu_pkg::tok_flags_t     tin,
  input  logic [USE_BITS-1:0]     tin_uses,
  input  logic [IDX_W-1:0]        tin_idx,
  input  logic [ID_BITS-1:0]      tin_file,
  input  logic [ID_BITS-1:0]      tin_seg,
  output lfu_pkg::tok_flags_t     tout,
  output logic [USE_BITS-1:0]     tout_uses,
  output logic [IDX_W-1:0]        tout_idx,
  output logic [ID_BITS-1:0]      tout_file,
  output logic [ID_BITS-1:0]      tout_seg
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [OCC_W-1:0] MY_POS = OCC_W'(INDEX);

  logic live;
  logic match;
  logic take_min;
  logic bump;

  assign live     = MY_POS < occ;
  assign match    = live && (ent_file == key_file) && (ent_seg == key_seg);
  assign take_min = live && (!tin.have || (ent_uses < tin_uses));
  // only the oldest matching entry counts the read
  assign bump     = tin.active && is_read && match && !tin.found && (ent_uses != '1);

  always_ff @(posedge clk) begin
    priority if (cmd.en && (MY_IDX == append_idx)) begin
      ent_file <= key_file;
      ent_seg  <= key_seg;
      ent_uses <= USE_BITS'(1);
    end else if (cmd.en && cmd.evict && (MY_IDX >= victim_idx) && (MY_IDX < append_idx)) begin
      ent_file <= nb_file;
      ent_seg  <= nb_seg;
      ent_uses <= nb_uses;
    end else if (bump) begin
      ent_uses <= ent_uses + USE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout.active <= tin.active;
      tout.found  <= tin.found | match;
      tout.have   <= tin.have | live;
    end
  end

  always_ff @(posedge clk) begin
    if (take_min) begin
      tout_uses <= ent_uses;
      tout_idx  <= MY_IDX;
      tout_file <= ent_file;
      tout_seg  <= ent_seg;
    end else begin
      tout_uses <= tin_uses;
      tout_idx  <= tin_idx;
      tout_file <= tin_file;
      tout_seg  <= tin_seg;
    end
  end

endmodule

@@ rtl/lfu_segment_buffer.sv @@
// LFU segment buffer: a table of up to CAPACITY (file id, segment id, use count)
// entries kept in insertion order inside a row of cells.
// req channel: valid/ready transfer of opcode, file_id, seg_id (read, write, find).
// rsp channel: valid/ready transfer of hit, evicted and the evicted ids, one per request.
// cfg channel: valid/ready transfer of capacity_in_use, always ready; write it only
// while no request is in flight.
// Each request sends a scan token down the cell row, one cell per cycle, which
// finds the oldest match (and bumps its count on a read) and the least used,
// oldest entry. One request is taken at a time, so a new request is accepted
// only once the token has left the cell row and the block is idle again.
// A finished response sits in an output register while the next request is
// accepted; if rsp is stalled, the block holds in its final step until the
// register frees up, then writes the table and loads the new response.
// Reset (rst, synchronous) empties the table and sets capacity_in_use to 64;
// entry contents need no clearing.
module lfu_segment_buffer #(
  parameter int CAPACITY = lfu_pkg::CAPACITY_DEF,
  parameter int ID_BITS  = lfu_pkg::ID_BITS_DEF,
  parameter int USE_BITS = lfu_pkg::USE_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  lfu_req_if.sink  req,
  lfu_rsp_if.source rsp,
  lfu_cfg_if.sink  cfg
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > lfu_pkg::CFG_W) ? OCC_W : lfu_pkg::CFG_W;

  lfu_pkg::state_t state, state_next;

  logic [lfu_pkg::CFG_W-1:0]    cap;
  logic [OCC_W-1:0]             occ;
  logic [lfu_pkg::OPCODE_W-1:0] it_op;
  logic [ID_BITS-1:0]           it_file;
  logic [ID_BITS-1:0]           it_seg;

  logic                         res_found;
  logic [IDX_W-1:0]             res_idx;
  logic [ID_BITS-1:0]           res_file;
  logic [ID_BITS-1:0]           res_seg;

  logic                         out_valid;
  logic                         out_hit;
  logic                         out_ev;
  logic [lfu_pkg::FIELD_W-1:0]  out_ef;
  logic [lfu_pkg::FIELD_W-1:0]  out_es;

  logic                         req_ready;
  logic                         start_tok;
  logic                         finish_go;
  logic                         out_free;
  logic                         is_read;
  logic                         is_write;
  logic                         evict_now;
  logic [lfu_pkg::CFG_W-1:0]    cap_min1;
  logic [IDX_W-1:0]             append_idx;
  lfu_pkg::commit_t             cmd;

  lfu_pkg::tok_flags_t          t_fl   [CAPACITY+1];
  logic [USE_BITS-1:0]          t_uses [CAPACITY+1];
  logic [IDX_W-1:0]             t_idx  [CAPACITY+1];
  logic [ID_BITS-1:0]           t_file [CAPACITY+1];
  logic [ID_BITS-1:0]           t_seg  [CAPACITY+1];

  logic [ID_BITS-1:0]           e_file [CAPACITY];
  logic [ID_BITS-1:0]           e_seg  [CAPACITY];
  logic [USE_BITS-1:0]          e_uses [CAPACITY];
  logic [ID_BITS-1:0]           n_file [CAPACITY];
  logic [ID_BITS-1:0]           n_seg  [CAPACITY];
  logic [USE_BITS-1:0]          n_uses [CAPACITY];

  assign out_free = !out_valid || rsp.ready;
  assign is_read  = it_op == lfu_pkg::OP_READ;
  assign is_write = it_op == lfu_pkg::OP_WRITE;

  // capacity of zero acts as one, above CAPACITY as CAPACITY
  assign cap_min1  = (cap == '0) ? lfu_pkg::CAP_MIN : cap;
  assign evict_now = (occ != '0) &&
                     ((occ >= OCC_W'(CAPACITY)) || (CMP_W'(occ) >= CMP_W'(cap_min1)));
  assign append_idx = evict_now ? IDX_W'(occ - OCC_W'(1)) : IDX_W'(occ);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::ST_IDLE:   if (req.valid) state_next = lfu_pkg::ST_START;
      lfu_pkg::ST_START:  state_next = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN:   if (t_fl[CAPACITY].active) state_next = lfu_pkg::ST_FINISH;
      lfu_pkg::ST_FINISH: if (out_free) state_next = lfu_pkg::ST_IDLE;
      default:            state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready = 1'b0;
    start_tok = 1'b0;
    finish_go = 1'b0;
    unique case (state)
      lfu_pkg::ST_IDLE:   req_ready = 1'b1;
      lfu_pkg::ST_START:  start_tok = 1'b1;
      lfu_pkg::ST_SCAN:   ;
      lfu_pkg::ST_FINISH: finish_go = out_free;
      default:            ;
    endcase
  end

  assign cmd.en    = finish_go && is_write;
  assign cmd.evict = evict_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= lfu_pkg::CAP_RESET;
    end else if (cfg.valid) begin
      cap <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.en && !evict_now) begin
      occ <= occ + OCC_W'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_ready && req.valid) begin
      it_op   <= req.opcode;
      it_file <= ID_BITS'(req.file_id);
      it_seg  <= ID_BITS'(req.seg_id);
    end
  end

  // token leaving the last cell
  always_ff @(posedge clk) begin
    if (state == lfu_pkg::ST_SCAN && t_fl[CAPACITY].active) begin
      res_found <= t_fl[CAPACITY].found;
      res_idx   <= t_idx[CAPACITY];
      res_file  <= t_file[CAPACITY];
      res_seg   <= t_seg[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_hit <= (is_read || (it_op == lfu_pkg::OP_FIND)) && res_found;
      out_ev  <= is_write && evict_now;
      out_ef  <= (is_write && evict_now) ? lfu_pkg::FIELD_W'(res_file) : '0;
      out_es  <= (is_write && evict_now) ? lfu_pkg::FIELD_W'(res_seg) : '0;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.hit             = out_hit;
  assign rsp.evicted         = out_ev;
  assign rsp.evicted_file_id = out_ef;
  assign rsp.evicted_seg_id  = out_es;

  // fresh token into the head of the row
  assign t_fl[0].active = start_tok;
  assign t_fl[0].found  = 1'b0;
  assign t_fl[0].have   = 1'b0;
  assign t_uses[0]      = '0;
  assign t_idx[0]       = '0;
  assign t_file[0]      = '0;
  assign t_seg[0]       = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      assign n_file[i] = '0;
      assign n_seg[i]  = '0;
      assign n_uses[i] = '0;
    end else begin : g_body
      assign n_file[i] = e_file[i+1];
      assign n_seg[i]  = e_seg[i+1];
      assign n_uses[i] = e_uses[i+1];
    end

    lfu_cell #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS),
      .USE_BITS (USE_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .occ        (occ),
      .is_read    (is_read),
      .key_file   (it_file),
      .key_seg    (it_seg),
      .cmd        (cmd),
      .victim_idx (res_idx),
      .append_idx (append_idx),
      .nb_file    (n_file[i]),
      .nb_seg     (n_seg[i]),
      .nb_uses    (n_uses[i]),
      .ent_file   (e_file[i]),
      .ent_seg    (e_seg[i]),
      .ent_uses   (e_uses[i]),
      .tin        (t_fl[i]),
      .tin_uses   (t_uses[i]),
      .tin_idx    (t_idx[i]),
      .tin_file   (t_file[i]),
      .tin_seg    (t_seg[i]),
      .tout       (t_fl[i+1]),
      .tout_uses  (t_uses[i+1]),
      .tout_idx   (t_idx[i+1]),
      .tout_file  (t_file[i+1]),
      .tout_seg   (t_seg[i+1])
    );
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_DEPTH = lfu_pkg::CAPACITY_DEF;
  localparam int N_DIRECTED = 28;
  localparam int N_RANDOM = 1670;
  localparam int N_PHASES = 12;
  localparam int POOL = 96;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam logic [lfu_pkg::OPCODE_W-1:0] OP_NONE = 2'd3;
  localparam logic [lfu_pkg::FIELD_W-1:0] USE_MAX = '1;

  typedef struct packed {
    logic hit;
    logic evicted;
    logic [lfu_pkg::FIELD_W-1:0] ev_file;
    logic [lfu_pkg::FIELD_W-1:0] ev_seg;
  } access_result_t;

  typedef enum logic {ROW_ACC, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [lfu_pkg::OPCODE_W-1:0] op;
    logic [lfu_pkg::FIELD_W-1:0] fid;
    logic [lfu_pkg::FIELD_W-1:0] sid;
    logic [lfu_pkg::CFG_W-1:0] cap;
    logic typed;
    access_result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lfu_req_if req();
  lfu_rsp_if rsp();
  lfu_cfg_if cfg();

  lfu_segment_buffer dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always #4 clk = ~clk;

  logic [lfu_pkg::FIELD_W-1:0] seg_file [TABLE_DEPTH];
  logic [lfu_pkg::FIELD_W-1:0] seg_id [TABLE_DEPTH];
  logic [lfu_pkg::FIELD_W-1:0] seg_uses [TABLE_DEPTH];
  int fill = 0;
  logic [lfu_pkg::CFG_W-1:0] cap_setting = lfu_pkg::CAP_RESET;

  access_result_t pending_results [$];
  row_t directed [N_DIRECTED];
  logic [2*lfu_pkg::FIELD_W-1:0] id_pool [POOL];

  int n_errors = 0;
  int n_access = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_evictions = 0;
  int n_cap_writes = 0;
  int idle_cycles = 0;
  int ready_hold = 0;
  logic quiet = 1'b0;

  function automatic int capacity_limit();
    if (cap_setting < lfu_pkg::CAP_MIN) return lfu_pkg::CAP_MIN;
    if (cap_setting > TABLE_DEPTH) return TABLE_DEPTH;
    return cap_setting;
  endfunction

  function automatic access_result_t apply_access(logic [lfu_pkg::OPCODE_W-1:0] op,
                                                  logic [lfu_pkg::FIELD_W-1:0] fid,
                                                  logic [lfu_pkg::FIELD_W-1:0] sid);
    access_result_t r;
    int idx;
    int victim;
    r = '0;
    idx = -1;
    for (int i = 0; i < fill; i++)
      if (idx < 0 && seg_file[i] == fid && seg_id[i] == sid) idx = i;
    case (op)
      lfu_pkg::OP_READ: begin
        if (idx >= 0) begin
          r.hit = 1'b1;
          if (seg_uses[idx] != USE_MAX) seg_uses[idx] = seg_uses[idx] + 1'b1;
        end
      end
      lfu_pkg::OP_FIND: r.hit = (idx >= 0);
      lfu_pkg::OP_WRITE: begin
        if (fill >= capacity_limit() && fill > 0) begin
          victim = 0;
          for (int i = 1; i < fill; i++)
            if (seg_uses[i] < seg_uses[victim]) victim = i;
          r.evicted = 1'b1;
          r.ev_file = seg_file[victim];
          r.ev_seg = seg_id[victim];
          for (int i = victim; i < fill - 1; i++) begin
            seg_file[i] = seg_file[i+1];
            seg_id[i] = seg_id[i+1];
            seg_uses[i] = seg_uses[i+1];
          end
          fill--;
        end
        if (fill < TABLE_DEPTH) begin
          seg_file[fill] = fid;
          seg_id[fill] = sid;
          seg_uses[fill] = lfu_pkg::FIELD_W'(1);
          fill++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic row_t row_acc(logic [lfu_pkg::OPCODE_W-1:0] op,
                                   logic [lfu_pkg::FIELD_W-1:0] fid,
                                   logic [lfu_pkg::FIELD_W-1:0] sid);
    row_t r;
    r = '0;
    r.kind = ROW_ACC;
    r.op = op;
    r.fid = fid;
    r.sid = sid;
    return r;
  endfunction

  function automatic row_t row_chk(logic [lfu_pkg::OPCODE_W-1:0] op,
                                   logic [lfu_pkg::FIELD_W-1:0] fid,
                                   logic [lfu_pkg::FIELD_W-1:0] sid, logic hit, logic ev,
                                   logic [lfu_pkg::FIELD_W-1:0] ef,
                                   logic [lfu_pkg::FIELD_W-1:0] es);
    row_t r;
    r = row_acc(op, fid, sid);
    r.typed = 1'b1;
    r.want = '{hit, ev, ef, es};
    return r;
  endfunction

  function automatic row_t row_cap(logic [lfu_pkg::CFG_W-1:0] cap);
    row_t r;
    r = '0;
    r.kind = ROW_CAP;
    r.cap = cap;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // response side backpressure
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      rsp.ready <= 1'b1;
      ready_hold <= $urandom_range(0, 4);
    end else begin
      rsp.ready <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 70);
    end
  end

  always @(posedge clk) begin
    access_result_t got;
    access_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.hit, rsp.evicted, rsp.evicted_file_id, rsp.evicted_seg_id};
      n_results++;
      n_hits += got.hit;
      n_evictions += got.evicted;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: response transfer with nothing expected, got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) begin
          n_errors++;
          $display("%0t: hit expected %h got %h", $time, want.hit, got.hit);
        end
        if (got.evicted !== want.evicted) begin
          n_errors++;
          $display("%0t: evicted expected %h got %h", $time, want.evicted, got.evicted);
        end
        if (got.ev_file !== want.ev_file) begin
          n_errors++;
          $display("%0t: evicted_file_id expected %h got %h", $time, want.ev_file,
                   got.ev_file);
        end
        if (got.ev_seg !== want.ev_seg) begin
          n_errors++;
          $display("%0t: evicted_seg_id expected %h got %h", $time, want.ev_seg, got.ev_seg);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue(logic [lfu_pkg::OPCODE_W-1:0] op, logic [lfu_pkg::FIELD_W-1:0] fid,
                       logic [lfu_pkg::FIELD_W-1:0] sid, logic typed, access_result_t want);
    access_result_t predicted;
    int gap;
    req.valid <= 1'b1;
    req.opcode <= op;
    req.file_id <= fid;
    req.seg_id <= sid;
    do @(posedge clk); while (!req.ready);
    predicted = apply_access(op, fid, sid);
    pending_results = {pending_results, (typed ? want : predicted)};
    if (op != OP_NONE) n_access++;
    gap = gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [lfu_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    cap_setting = value;
    n_cap_writes++;
  endtask

  initial begin
    logic [lfu_pkg::CFG_W-1:0] phase_caps [N_PHASES];
    logic [lfu_pkg::OPCODE_W-1:0] op;
    logic [2*lfu_pkg::FIELD_W-1:0] pair;
    int r;
    int span;
    int count;

    req.valid = 1'b0;
    req.opcode = lfu_pkg::OP_READ;
    req.file_id = '0;
    req.seg_id = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;

    directed = '{
      row_chk(lfu_pkg::OP_READ, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_FIND, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_chk(OP_NONE, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_WRITE, 16'hffff, 16'hffff, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_WRITE, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_READ, 16'hffff, 16'hffff, 1'b1, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_READ, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_FIND, 16'hffff, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_FIND, 16'h0000, 16'hffff, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_chk(lfu_pkg::OP_FIND, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000),
      row_cap(7'd3),
      row_chk(lfu_pkg::OP_WRITE, 16'h1234, 16'h5678, 1'b0, 1'b1, 16'h0000, 16'h0000),
      row_acc(lfu_pkg::OP_READ, 16'h1234, 16'h5678),
      // all counts tied, oldest goes
      row_chk(lfu_pkg::OP_WRITE, 16'h8001, 16'h7ffe, 1'b0, 1'b1, 16'h0000, 16'h0000),
      row_cap(7'd0),
      row_chk(lfu_pkg::OP_WRITE, 16'h7ffe, 16'h8001, 1'b0, 1'b1, 16'h8001, 16'h7ffe),
      row_acc(lfu_pkg::OP_FIND, 16'h7ffe, 16'h8001),
      row_acc(lfu_pkg::OP_READ, 16'hffff, 16'hffff),
      row_acc(lfu_pkg::OP_WRITE, 16'h00ff, 16'hff00),
      row_cap(7'd127),
      row_chk(lfu_pkg::OP_WRITE, 16'hff00, 16'h00ff, 1'b0, 1'b0, 16'h0000, 16'h0000),
      row_acc(lfu_pkg::OP_READ, 16'hff00, 16'h00ff),
      row_acc(lfu_pkg::OP_READ, 16'h00ff, 16'hff00),
      row_acc(lfu_pkg::OP_FIND, 16'h1234, 16'h5678),
      row_cap(7'd1),
      row_acc(lfu_pkg::OP_WRITE, 16'h5a5a, 16'ha5a5),
      row_chk(OP_NONE, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000)
    };

    phase_caps = '{7'd6, 7'd2, 7'd24, 7'd64, 7'd127, 7'd0, 7'd1,
                   lfu_pkg::CFG_W'($urandom_range(0, 127)), 7'd48,
                   lfu_pkg::CFG_W'($urandom_range(0, 127)), 7'd64, 7'd100};
    foreach (id_pool[i]) id_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_CAP) set_capacity(directed[k].cap);
      else issue(directed[k].op, directed[k].fid, directed[k].sid, directed[k].typed,
                 directed[k].want);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      set_capacity(phase_caps[phase]);
      quiet = ($urandom_range(0, 3) == 0);
      span = capacity_limit() + 6;
      if (span > POOL) span = POOL;
      count = 0;
      while (count < N_RANDOM / N_PHASES) begin
        r = $urandom_range(0, 99);
        op = (r < 40) ? lfu_pkg::OP_READ : (r < 75) ? lfu_pkg::OP_WRITE :
             (r < 95) ? lfu_pkg::OP_FIND : OP_NONE;
        if ($urandom_range(0, 4) != 0) begin
          pair = id_pool[$urandom_range(0, span - 1)];
        end else begin
          pair = $urandom;
          if (op == lfu_pkg::OP_WRITE) id_pool[$urandom_range(0, span - 1)] = pair;
        end
        issue(op, pair[2*lfu_pkg::FIELD_W-1:lfu_pkg::FIELD_W], pair[lfu_pkg::FIELD_W-1:0],
              1'b0, '0);
        count++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d accesses, %0d responses with %0d hits and %0d evictions",
             n_access, n_results, n_hits, n_evictions);
    $display("capacity written %0d times, extremes 0, 1, 64 and 127 included", n_cap_writes);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
